### rtl/efb_pkg.sv
// Shared types and constants for the eye pair face box pipeline.
// No dependencies; imported by efb_cordic and eye_pair_face_box.
`timescale 1ns / 1ps

package efb_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int ANG_W        = 16;
    localparam int ZW           = 17;

    typedef logic signed [ZW-1:0]    t_zacc;
    typedef logic signed [ANG_W-1:0] t_angle;

    localparam t_zacc PI_Q13 = 17'sd25736;

    // Step angles atan(2^-i) in Q13.
    function automatic t_zacc atan_q13(input int unsigned idx);
        t_zacc v;
        case (idx)
            0:       v = 17'sd6434;
            1:       v = 17'sd3798;
            2:       v = 17'sd2007;
            3:       v = 17'sd1019;
            4:       v = 17'sd511;
            5:       v = 17'sd256;
            6:       v = 17'sd128;
            7:       v = 17'sd64;
            8:       v = 17'sd32;
            9:       v = 17'sd16;
            10:      v = 17'sd8;
            11:      v = 17'sd4;
            12:      v = 17'sd2;
            13:      v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/efb_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// No package dependency; a side word travels alongside each radicand.
`timescale 1ns / 1ps

module efb_sqrt #(
    parameter int QW = 29,
    parameter int TW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [2*QW-1:0] i_rad,
    input  logic [TW-1:0]   i_tag,
    output logic            o_vld,
    output logic [QW-1:0]   o_root,
    output logic [TW-1:0]   o_tag
);

    localparam int RMW = QW + 3;

    wire            w_vld  [0:QW];
    wire [RMW-1:0]  w_rem  [0:QW];
    wire [QW-1:0]   w_root [0:QW];
    wire [2*QW-1:0] w_rad  [0:QW];
    wire [TW-1:0]   w_tag  [0:QW];

    assign w_vld[0]  = i_vld;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = i_rad;
    assign w_tag[0]  = i_tag;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic            r_vld;
        logic [RMW-1:0]  r_rem;
        logic [QW-1:0]   r_root;
        logic [2*QW-1:0] r_rad;
        logic [TW-1:0]   r_tag;
        logic [RMW-1:0]  n_rem;
        logic [QW-1:0]   n_root;
        logic [RMW-1:0]  w_try;
        logic [RMW-1:0]  w_trial;

        always_comb begin
            w_try   = {w_rem[k][RMW-3:0], w_rad[k][2*QW-1 -: 2]};
            w_trial = RMW'({w_root[k], 2'b01});
            if (w_try >= w_trial) begin
                n_rem  = w_try - w_trial;
                n_root = {w_root[k][QW-2:0], 1'b1};
            end else begin
                n_rem  = w_try;
                n_root = {w_root[k][QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= w_rad[k] << 2;
            r_tag  <= w_tag[k];
        end

        assign w_vld[k+1]  = r_vld;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_rad[k+1]  = r_rad;
        assign w_tag[k+1]  = r_tag;
    end

    assign o_vld  = w_vld[QW];
    assign o_root = w_root[QW];
    assign o_tag  = w_tag[QW];

endmodule

### rtl/efb_cordic.sv
// Pipelined vectoring CORDIC giving the eye line angle in Q13 radians.
// Depends on efb_pkg for the step angle table and angle types.
`timescale 1ns / 1ps

module efb_cordic #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16,
    parameter int TW         = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic signed [COORD_BITS:0] i_vx,
    input  logic signed [COORD_BITS:0] i_vy,
    input  logic [TW-1:0]            i_tag,
    output logic                     o_vld,
    output efb_pkg::t_angle          o_ang,
    output logic [TW-1:0]            o_tag
);

    import efb_pkg::*;

    localparam int XW = COORD_BITS + FRAC_BITS + 4;
    localparam int NS = CORDIC_STEPS;

    wire                 w_vld [0:NS];
    wire signed [XW-1:0] w_x   [0:NS];
    wire signed [XW-1:0] w_y   [0:NS];
    wire signed [ZW-1:0] w_z   [0:NS];
    wire [TW-1:0]        w_tag [0:NS];

    // Left half-plane vectors are first turned by pi.
    logic                r_p_vld;
    logic signed [XW-1:0] r_p_x, r_p_y, n_p_x, n_p_y;
    t_zacc               r_p_z, n_p_z;
    logic [TW-1:0]       r_p_tag;

    always_comb begin
        if (i_vx < 0) begin
            n_p_x = -(XW'(i_vx) <<< FRAC_BITS);
            n_p_y = -(XW'(i_vy) <<< FRAC_BITS);
            n_p_z = (i_vy >= 0) ? PI_Q13 : -PI_Q13;
        end else begin
            n_p_x = XW'(i_vx) <<< FRAC_BITS;
            n_p_y = XW'(i_vy) <<< FRAC_BITS;
            n_p_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_vld;
        end
        r_p_x   <= n_p_x;
        r_p_y   <= n_p_y;
        r_p_z   <= n_p_z;
        r_p_tag <= i_tag;
    end

    assign w_vld[0] = r_p_vld;
    assign w_x[0]   = r_p_x;
    assign w_y[0]   = r_p_y;
    assign w_z[0]   = r_p_z;
    assign w_tag[0] = r_p_tag;

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic                 r_vld;
        logic signed [XW-1:0] r_x, r_y, n_x, n_y;
        t_zacc                r_z, n_z;
        logic [TW-1:0]        r_tag;

        always_comb begin
            n_x = w_x[k];
            n_y = w_y[k];
            n_z = w_z[k];
            if (w_y[k] > 0) begin
                n_x = w_x[k] + (w_y[k] >>> k);
                n_y = w_y[k] - (w_x[k] >>> k);
                n_z = w_z[k] + atan_q13(k);
            end else if (w_y[k] < 0) begin
                n_x = w_x[k] - (w_y[k] >>> k);
                n_y = w_y[k] + (w_x[k] >>> k);
                n_z = w_z[k] - atan_q13(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= w_tag[k];
        end

        assign w_vld[k+1] = r_vld;
        assign w_x[k+1]   = r_x;
        assign w_y[k+1]   = r_y;
        assign w_z[k+1]   = r_z;
        assign w_tag[k+1] = r_tag;
    end

    // The accumulated angle can overshoot pi by the residual step error.
    logic          r_o_vld;
    t_angle        r_o_ang, n_o_ang;
    logic [TW-1:0] r_o_tag;

    always_comb begin
        if (w_z[NS] > PI_Q13) begin
            n_o_ang = ANG_W'(PI_Q13);
        end else if (w_z[NS] < -PI_Q13) begin
            n_o_ang = ANG_W'(-PI_Q13);
        end else begin
            n_o_ang = ANG_W'(w_z[NS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= w_vld[NS];
        end
        r_o_ang <= n_o_ang;
        r_o_tag <= w_tag[NS];
    end

    assign o_vld = r_o_vld;
    assign o_ang = r_o_ang;
    assign o_tag = r_o_tag;

endmodule

### rtl/efb_div.sv
// Pipelined pair of restoring dividers giving cosine and sine of the tilt.
// No package dependency; both quotients share the eye distance as divisor.
`timescale 1ns / 1ps

module efb_div #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16,
    parameter int QW         = 29,
    parameter int TW         = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic signed [COORD_BITS:0] i_na,
    input  logic signed [COORD_BITS:0] i_nb,
    input  logic [QW-1:0]              i_den,
    input  logic [TW-1:0]              i_tag,
    output logic                       o_vld,
    output logic signed [FRAC_BITS+1:0] o_qa,
    output logic signed [FRAC_BITS+1:0] o_qb,
    output logic [TW-1:0]              o_tag
);

    localparam int F   = FRAC_BITS;
    localparam int RMW = QW + 1;
    localparam int NS  = F + 1;
    localparam int OW  = F + 2;

    // The quotient is known to stay below 2^(F+1), so the top of the
    // shifted numerator is loaded straight into the remainder.
    logic              r_i_vld;
    logic [RMW-1:0]    r_i_ra, r_i_rb;
    logic              r_i_sa, r_i_sb, r_i_zero;
    logic [QW-1:0]     r_i_den;
    logic [TW-1:0]     r_i_tag;
    logic [COORD_BITS:0] w_ma, w_mb;

    always_comb begin
        w_ma = i_na[COORD_BITS] ? unsigned'(-i_na) : unsigned'(i_na);
        w_mb = i_nb[COORD_BITS] ? unsigned'(-i_nb) : unsigned'(i_nb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else begin
            r_i_vld <= i_vld;
        end
        r_i_ra   <= RMW'(w_ma) << (F - 1);
        r_i_rb   <= RMW'(w_mb) << (F - 1);
        r_i_sa   <= i_na[COORD_BITS];
        r_i_sb   <= i_nb[COORD_BITS];
        r_i_zero <= (i_den == '0);
        r_i_den  <= i_den;
        r_i_tag  <= i_tag;
    end

    wire              w_vld  [0:NS];
    wire [RMW-1:0]    w_ra   [0:NS];
    wire [RMW-1:0]    w_rb   [0:NS];
    wire [F:0]        w_qa   [0:NS];
    wire [F:0]        w_qb   [0:NS];
    wire [2:0]        w_flg  [0:NS];
    wire [QW-1:0]     w_den  [0:NS];
    wire [TW-1:0]     w_tag  [0:NS];

    assign w_vld[0] = r_i_vld;
    assign w_ra[0]  = r_i_ra;
    assign w_rb[0]  = r_i_rb;
    assign w_qa[0]  = '0;
    assign w_qb[0]  = '0;
    assign w_flg[0] = {r_i_zero, r_i_sb, r_i_sa};
    assign w_den[0] = r_i_den;
    assign w_tag[0] = r_i_tag;

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic          r_vld;
        logic [RMW-1:0] r_ra, r_rb, n_ra, n_rb;
        logic [F:0]    r_qa, r_qb, n_qa, n_qb;
        logic [2:0]    r_flg;
        logic [QW-1:0] r_den;
        logic [TW-1:0] r_tag;
        logic [RMW-1:0] w_ta, w_tb, w_dv;

        always_comb begin
            w_ta = {w_ra[k][RMW-2:0], 1'b0};
            w_tb = {w_rb[k][RMW-2:0], 1'b0};
            w_dv = RMW'(w_den[k]);
            if (w_ta >= w_dv) begin
                n_ra = w_ta - w_dv;
                n_qa = {w_qa[k][F-1:0], 1'b1};
            end else begin
                n_ra = w_ta;
                n_qa = {w_qa[k][F-1:0], 1'b0};
            end
            if (w_tb >= w_dv) begin
                n_rb = w_tb - w_dv;
                n_qb = {w_qb[k][F-1:0], 1'b1};
            end else begin
                n_rb = w_tb;
                n_qb = {w_qb[k][F-1:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
            r_ra  <= n_ra;
            r_rb  <= n_rb;
            r_qa  <= n_qa;
            r_qb  <= n_qb;
            r_flg <= w_flg[k];
            r_den <= w_den[k];
            r_tag <= w_tag[k];
        end

        assign w_vld[k+1] = r_vld;
        assign w_ra[k+1]  = r_ra;
        assign w_rb[k+1]  = r_rb;
        assign w_qa[k+1]  = r_qa;
        assign w_qb[k+1]  = r_qb;
        assign w_flg[k+1] = r_flg;
        assign w_den[k+1] = r_den;
        assign w_tag[k+1] = r_tag;
    end

    // Clamp to one, apply the signs, and force cos=1, sin=0 at zero distance.
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic                 r_o_vld;
    logic signed [OW-1:0] r_o_qa, r_o_qb, n_o_qa, n_o_qb;
    logic [TW-1:0]        r_o_tag;
    logic [F:0]           w_ca, w_cb;

    always_comb begin
        w_ca = (w_qa[NS] > ONE) ? ONE : w_qa[NS];
        w_cb = (w_qb[NS] > ONE) ? ONE : w_qb[NS];
        n_o_qa = w_flg[NS][0] ? -signed'(OW'(w_ca)) : signed'(OW'(w_ca));
        n_o_qb = w_flg[NS][1] ? -signed'(OW'(w_cb)) : signed'(OW'(w_cb));
        if (w_flg[NS][2]) begin
            n_o_qa = signed'(OW'(ONE));
            n_o_qb = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= w_vld[NS];
        end
        r_o_qa  <= n_o_qa;
        r_o_qb  <= n_o_qb;
        r_o_tag <= w_tag[NS];
    end

    assign o_vld = r_o_vld;
    assign o_qa  = r_o_qa;
    assign o_qb  = r_o_qb;
    assign o_tag = r_o_tag;

endmodule

### rtl/eye_pair_face_box.sv
// Top level of the eye pair face box: differences, square root, CORDIC,
// dividers and box arithmetic. Uses efb_pkg, efb_sqrt, efb_cordic, efb_div.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------------
//  input    | start, busy      | i_left_x, i_left_y, i_right_x, i_right_y,
//           |                  | i_left_found, i_right_found
//  result   | o_done (strobe)  | o_found, o_box_x, o_box_y, o_box_width,
//           |                  | o_box_height, o_tilt_angle
//
// One word is taken every clock cycle; busy is always low.
// QW = (2*COORD_BITS + 2*FRAC_BITS + 2) / 2 is the root width, 29 at the
// defaults; the root and divider pipelines produce one bit per stage.
// Reset clears only the stage valid flags. The receiver cannot stall, so the
// pipeline advances every cycle and each result shows for a single cycle.
`timescale 1ns / 1ps

module eye_pair_face_box #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [COORD_BITS-1:0]       i_left_x,
    input  logic [COORD_BITS-1:0]       i_left_y,
    input  logic [COORD_BITS-1:0]       i_right_x,
    input  logic [COORD_BITS-1:0]       i_right_y,
    input  logic                        i_left_found,
    input  logic                        i_right_found,
    output logic                        o_done,
    output logic                        o_found,
    output logic signed [COORD_BITS+2:0] o_box_x,
    output logic signed [COORD_BITS+2:0] o_box_y,
    output logic [COORD_BITS+1:0]       o_box_width,
    output logic [COORD_BITS:0]         o_box_height,
    output efb_pkg::t_angle             o_tilt_angle
);

    import efb_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DW   = CW + 1;
    localparam int D2W  = 2 * CW + 1;
    localparam int QW   = (D2W + 2 * F + 1) / 2;
    localparam int RADW = 2 * QW;
    localparam int KW   = F + 1;
    localparam int BXW  = CW + 3;
    localparam int BWW  = CW + 2;
    localparam int BHW  = CW + 1;
    localparam int CSW  = F + 2;
    localparam int PW   = CSW + BWW + 1;
    localparam int TAW  = 1 + 2 * DW + 2 * CW;
    localparam int TBW  = QW + TAW;
    localparam int TCW  = ANG_W + QW + TAW;

    localparam longint unsigned K_L = ((64'd156 << F) + 64'd50) / 64'd100;
    localparam logic [KW-1:0] K_WIDTH = KW'(K_L);

    assign busy = 1'b0;

    // Input register: eye differences.
    logic                  r0_vld, r0_found;
    logic signed [DW-1:0]  r0_dx, r0_dy;
    logic [CW-1:0]         r0_rx, r0_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start && !busy;
        end
        r0_found <= i_left_found && i_right_found;
        r0_dx    <= signed'({1'b0, i_left_x}) - signed'({1'b0, i_right_x});
        r0_dy    <= signed'({1'b0, i_left_y}) - signed'({1'b0, i_right_y});
        r0_rx    <= i_right_x;
        r0_ry    <= i_right_y;
    end

    // Squared distance.
    logic                   r1_vld;
    logic [D2W-1:0]         r1_d2;
    logic [TAW-1:0]         r1_tag;
    logic signed [D2W+1:0]  w_d2s;

    assign w_d2s = (D2W+2)'(r0_dx) * (D2W+2)'(r0_dx)
                 + (D2W+2)'(r0_dy) * (D2W+2)'(r0_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
        r1_d2  <= w_d2s[D2W-1:0];
        r1_tag <= {r0_found, r0_dx, r0_dy, r0_rx, r0_ry};
    end

    // Distance in QF.
    logic            sq_vld;
    logic [QW-1:0]   sq_root;
    logic [TAW-1:0]  sq_tag;
    logic [RADW-1:0] w_rad;

    assign w_rad = RADW'(r1_d2) << (2 * F);

    efb_sqrt #(.QW(QW), .TW(TAW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r1_vld),
        .i_rad   (w_rad),
        .i_tag   (r1_tag),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    logic signed [DW-1:0] sq_dx, sq_dy;

    assign sq_dx = sq_tag[2*CW+DW +: DW];
    assign sq_dy = sq_tag[2*CW +: DW];

    // Tilt angle.
    logic           co_vld;
    t_angle         co_ang;
    logic [TBW-1:0] co_tag;

    efb_cordic #(.COORD_BITS(CW), .FRAC_BITS(F), .TW(TBW)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sq_vld),
        .i_vx    (sq_dx),
        .i_vy    (-sq_dy),
        .i_tag   ({sq_root, sq_tag}),
        .o_vld   (co_vld),
        .o_ang   (co_ang),
        .o_tag   (co_tag)
    );

    logic [QW-1:0]        co_dq;
    logic signed [DW-1:0] co_dx, co_dy;

    assign co_dq = co_tag[TAW +: QW];
    assign co_dx = co_tag[2*CW+DW +: DW];
    assign co_dy = co_tag[2*CW +: DW];

    // Cosine and sine of the tilt.
    logic                  dv_vld;
    logic signed [CSW-1:0] dv_c, dv_s;
    logic [TCW-1:0]        dv_tag;

    efb_div #(.COORD_BITS(CW), .FRAC_BITS(F), .QW(QW), .TW(TCW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (co_vld),
        .i_na    (co_dx),
        .i_nb    (-co_dy),
        .i_den   (co_dq),
        .i_tag   ({co_ang, co_tag}),
        .o_vld   (dv_vld),
        .o_qa    (dv_c),
        .o_qb    (dv_s),
        .o_tag   (dv_tag)
    );

    t_angle               dv_ang;
    logic [QW-1:0]        dv_dq;
    logic                 dv_found;
    logic signed [DW-1:0] dv_dx, dv_dy;
    logic [CW-1:0]        dv_rx, dv_ry;

    assign {dv_ang, dv_dq, dv_found, dv_dx, dv_dy, dv_rx, dv_ry} = dv_tag;

    // Width, midpoint.
    logic                  r_m1_vld, r_m1_found;
    logic [BWW-1:0]        r_m1_w;
    logic signed [CSW-1:0] r_m1_c, r_m1_s;
    logic signed [BXW-1:0] r_m1_mx, r_m1_my;
    t_angle                r_m1_ang;
    logic [QW+KW-1:0]      w_wprod;

    assign w_wprod = (QW+KW)'(dv_dq) * (QW+KW)'(K_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= dv_vld;
        end
        r_m1_found <= dv_found;
        r_m1_w     <= w_wprod[2*F +: BWW];
        r_m1_c     <= dv_c;
        r_m1_s     <= dv_s;
        r_m1_mx    <= BXW'(signed'({1'b0, dv_rx})) + BXW'(dv_dx >>> 1);
        r_m1_my    <= BXW'(signed'({1'b0, dv_ry})) + BXW'(dv_dy >>> 1);
        r_m1_ang   <= dv_ang;
    end

    // Rotation products.
    logic                  r_m2_vld, r_m2_found;
    logic signed [PW-1:0]  r_m2_cw, r_m2_sh, r_m2_sw, r_m2_ch;
    logic [BWW-1:0]        r_m2_w;
    logic signed [BXW-1:0] r_m2_mx, r_m2_my;
    t_angle                r_m2_ang;
    logic signed [PW-1:0]  w_ws, w_hs, w_cs, w_ss;

    assign w_ws = PW'(signed'({1'b0, r_m1_w}));
    assign w_hs = PW'(signed'({2'b00, r_m1_w[BWW-1:1]}));
    assign w_cs = PW'(r_m1_c);
    assign w_ss = PW'(r_m1_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else begin
            r_m2_vld <= r_m1_vld;
        end
        r_m2_found <= r_m1_found;
        r_m2_cw    <= w_cs * w_ws;
        r_m2_sh    <= w_ss * w_hs;
        r_m2_sw    <= w_ss * w_ws;
        r_m2_ch    <= w_cs * w_hs;
        r_m2_w     <= r_m1_w;
        r_m2_mx    <= r_m1_mx;
        r_m2_my    <= r_m1_my;
        r_m2_ang   <= r_m1_ang;
    end

    // Box corner and output register; a missing eye zeroes the whole word.
    logic                  r_m3_vld, r_m3_found;
    logic signed [BXW-1:0] r_m3_bx, r_m3_by, n_m3_bx, n_m3_by;
    logic [BWW-1:0]        r_m3_w, n_m3_w;
    logic [BHW-1:0]        r_m3_h, n_m3_h;
    t_angle                r_m3_ang, n_m3_ang;
    logic signed [PW:0]    w_sx, w_sy;

    always_comb begin
        w_sx     = (PW+1)'(r_m2_cw) + (PW+1)'(r_m2_sh);
        w_sy     = (PW+1)'(r_m2_sw) - (PW+1)'(r_m2_ch);
        n_m3_bx  = r_m2_mx - BXW'(w_sx >>> (F + 1));
        n_m3_by  = r_m2_my + BXW'(w_sy >>> (F + 1));
        n_m3_w   = r_m2_w;
        n_m3_h   = r_m2_w[BWW-1:1];
        n_m3_ang = r_m2_ang;
        if (!r_m2_found) begin
            n_m3_bx  = '0;
            n_m3_by  = '0;
            n_m3_w   = '0;
            n_m3_h   = '0;
            n_m3_ang = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else begin
            r_m3_vld <= r_m2_vld;
        end
        r_m3_found <= r_m2_found;
        r_m3_bx    <= n_m3_bx;
        r_m3_by    <= n_m3_by;
        r_m3_w     <= n_m3_w;
        r_m3_h     <= n_m3_h;
        r_m3_ang   <= n_m3_ang;
    end

    assign o_done       = r_m3_vld;
    assign o_found      = r_m3_found;
    assign o_box_x      = r_m3_bx;
    assign o_box_y      = r_m3_by;
    assign o_box_width  = r_m3_w;
    assign o_box_height = r_m3_h;
    assign o_tilt_angle = r_m3_ang;

    a_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_found |-> o_box_x == 0 && o_box_y == 0 && o_box_width == 0
                               && o_box_height == 0 && o_tilt_angle == 0)
        else $error("missing eye gave a non-zero box");

    a_height_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_box_height == o_box_width[BWW-1:1])
        else $error("box height is not half the width");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_tilt_angle <= 16'sd25736 && o_tilt_angle >= -16'sd25736)
        else $error("tilt angle beyond pi");

    a_stage_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m1_vld |=> r_m2_vld ##1 o_done)
        else $error("word lost in the box arithmetic stages");

endmodule

### test/eye_pair_face_box_test.sv
// Testbench for eye_pair_face_box: drives eye pairs, predicts the face box
// in fixed point and compares every result word. Depends on efb_pkg and the RTL.
`timescale 1ns / 1ps

module eye_pair_face_box_test;
    import efb_pkg::*;

    localparam int CB = 12;
    localparam int FB = 16;
    localparam int LATENCY = 69;

    typedef struct {
        logic                found;
        logic signed [14:0]  bx;
        logic signed [14:0]  by;
        logic [13:0]         w;
        logic [12:0]         h;
        logic signed [15:0]  ang;
    } t_box;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [CB-1:0] i_left_x = '0, i_left_y = '0, i_right_x = '0, i_right_y = '0;
    logic i_left_found = 1'b0, i_right_found = 1'b0;
    logic o_done, o_found;
    logic signed [CB+2:0] o_box_x, o_box_y;
    logic [CB+1:0] o_box_width;
    logic [CB:0] o_box_height;
    t_angle o_tilt_angle;

    t_box boxes_due[$];
    int errors = 0;

    eye_pair_face_box DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_root(longint unsigned v);
        longint unsigned res = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint unit_part(longint num, longint den);
        longint mag = (num < 0) ? -num : num;
        longint q = (mag <<< (2 * FB)) / den;
        if (q > (64'sd1 <<< FB)) q = 64'sd1 <<< FB;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint eye_line_angle(longint vx, longint vy);
        longint x, y, nx, z;
        z = 0;
        if (vx < 0) begin
            x = -vx;
            y = -vy;
            z = (vy >= 0) ? PI_Q13 : -PI_Q13;
        end else begin
            x = vx;
            y = vy;
        end
        x = x <<< FB;
        y = y <<< FB;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            nx = x;
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_q13(i);
            end else if (y < 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_q13(i);
            end
            x = nx;
        end
        if (z > PI_Q13) z = PI_Q13;
        if (z < -PI_Q13) z = -PI_Q13;
        return z;
    endfunction

    function automatic t_box face_box(int lx, int ly, int rx, int ry, bit lf, bit rf);
        t_box r;
        longint dx, dy, dq, k, w, h, c, s, bx, by;
        r = '{1'b0, '0, '0, '0, '0, '0};
        if (!lf || !rf) return r;
        dx = lx - rx;
        dy = ly - ry;
        dq = int_root(longint'(dx * dx + dy * dy) <<< (2 * FB));
        k = ((64'sd156 <<< FB) + 50) / 100;
        w = (dq * k) >>> (2 * FB);
        h = w >>> 1;
        if (dq == 0) begin
            c = 64'sd1 <<< FB;
            s = 0;
        end else begin
            c = unit_part(dx, dq);
            s = unit_part(-dy, dq);
        end
        bx = rx + floor_shift(dx, 1) - floor_shift(c * w + s * h, FB + 1);
        by = ry + floor_shift(dy, 1) + floor_shift(s * w - c * h, FB + 1);
        r.found = 1'b1;
        r.bx = bx[14:0];
        r.by = by[14:0];
        r.w = w[13:0];
        r.h = h[12:0];
        r.ang = 16'(eye_line_angle(dx, -dy));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Results are sampled on the falling edge so nothing races the driver.
    always @(negedge i_clk) begin
        t_box e;
        if (i_rst_n && o_done) begin
            if (boxes_due.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                e = boxes_due.pop_front();
                if (o_found !== e.found) report_mismatch("found", o_found, e.found);
                if (o_box_x !== e.bx) report_mismatch("box_x", o_box_x, e.bx);
                if (o_box_y !== e.by) report_mismatch("box_y", o_box_y, e.by);
                if (o_box_width !== e.w) report_mismatch("box_width", o_box_width, e.w);
                if (o_box_height !== e.h) report_mismatch("box_height", o_box_height, e.h);
                if (o_tilt_angle !== e.ang) report_mismatch("tilt", o_tilt_angle, e.ang);
            end
        end
    end

    task automatic send_pair(int lx, int ly, int rx, int ry, bit lf, bit rf, int gap);
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_left_x <= CB'(lx);
        i_left_y <= CB'(ly);
        i_right_x <= CB'(rx);
        i_right_y <= CB'(ry);
        i_left_found <= lf;
        i_right_found <= rf;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        boxes_due.push_back(face_box(lx, ly, rx, ry, lf, rf));
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (boxes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed;
        send_pair(0, 0, 0, 0, 1, 1, 0);
        send_pair(4095, 4095, 4095, 4095, 1, 1, 0);
        send_pair(4095, 4095, 0, 0, 1, 1, 0);
        send_pair(0, 0, 4095, 4095, 1, 1, 0);
        send_pair(4095, 0, 0, 4095, 1, 1, 0);
        send_pair(0, 4095, 4095, 0, 1, 1, 0);
        send_pair(100, 500, 300, 500, 1, 1, 0);   // horizontal, dx negative
        send_pair(300, 500, 100, 500, 1, 1, 0);
        send_pair(200, 100, 200, 900, 1, 1, 1);   // vertical lines
        send_pair(200, 900, 200, 100, 1, 1, 0);
        send_pair(1000, 1001, 1001, 1000, 1, 1, 0);
        send_pair(0, 1, 4095, 0, 1, 1, 0);        // near the angle clamp
        send_pair(0, 0, 4095, 1, 1, 1, 0);
        send_pair(123, 456, 789, 1011, 0, 1, 0);
        send_pair(123, 456, 789, 1011, 1, 0, 2);
        send_pair(4095, 4095, 4095, 4095, 0, 0, 0);
        drain();
    endtask

    task automatic test_random(int count);
        int lx, ly, rx, ry, gap, mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 9);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
            lx = $urandom_range(0, 4095);
            ly = $urandom_range(0, 4095);
            if (mode < 3) begin
                // Close eyes, as in real faces.
                rx = (lx + $urandom_range(0, 200)) % 4096;
                ry = (ly + $urandom_range(0, 40)) % 4096;
            end else begin
                rx = $urandom_range(0, 4095);
                ry = $urandom_range(0, 4095);
            end
            send_pair(lx, ly, rx, ry, (mode != 8), (mode != 9), gap);
            if (n == count / 2) drain();
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(2000);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && boxes_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
